>>> hdl/edge_to_vertex_scatter_add_assert.svh
// Assertion macros used by the scatter-add RTL.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef EDGE_TO_VERTEX_SCATTER_ADD_ASSERT_SVH
`define EDGE_TO_VERTEX_SCATTER_ADD_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every sampled edge.
`define EVSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition must never be true at a sampled edge.
`define EVSA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define EVSA_ASSERT(lbl, prop, msg)
`define EVSA_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/evsa_pkg.sv
package evsa_pkg;

	// Field widths of the item and result payloads.
	localparam int VERTEX_W = 8;
	localparam int LANE_W   = 6;
	localparam int VALUE_W  = 32;
	localparam int SUM_W    = 40;

	// Saturation limits of the Q24.16 accumulators.
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// Function codes of an input item.
	localparam logic [1:0] FUNC_ACC   = 2'd0;
	localparam logic [1:0] FUNC_RD    = 2'd1;
	localparam logic [1:0] FUNC_RDCLR = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MODE          = 2'd0;
	localparam logic [1:0] REG_VERTEX_COUNT  = 2'd1;
	localparam logic [1:0] REG_FEATURE_COUNT = 2'd2;

	// Register reset values.
	localparam logic [8:0] VERTEX_COUNT_RST  = 9'd256;
	localparam logic [6:0] FEATURE_COUNT_RST = 7'd64;

	// Operation kinds that reach the execution side.
	typedef enum logic [1:0] {
		OP_ACC,
		OP_RD,
		OP_RDCLR
	} kind_t;

	// One classified operation, as held in the queue.
	typedef struct packed {
		kind_t                      kind;
		logic [VERTEX_W-1:0]        vertex;
		logic [LANE_W-1:0]          lane;
		logic signed [VALUE_W-1:0]  value;
	} op_t;

	// Configuration as seen by the classifier.
	typedef struct packed {
		logic       mode;
		logic [8:0] vertex_count;
		logic [6:0] feature_count;
	} cfg_t;

endpackage

>>> hdl/edge_to_vertex_scatter_add.sv
// Scatter-add of edge feature elements into a per-vertex, per-lane accumulator
// store (MAX_VERTICES x MAX_LANES entries of 40-bit Q24.16, saturating). The
// front classifies each item (target vertex by mode, range checks, function
// code) and drops those that touch nothing; the rest pass through a four-entry
// queue to a read-modify-write unit on a single-port-write,
// registered-read memory, with the last write forwarded so that back-to-back
// updates of one entry stay exact. Sustained rate is one item per cycle while
// results are taken; a read result passes through the queue, the stage and the
// result register, and accumulate items hold the input only when the queue
// fills behind a stalled result. After reset, a clearing pass writes zero into
// every entry; item_ready stays low until it is done, while register writes
// are taken as usual.
module edge_to_vertex_scatter_add #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_LANES    = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,

	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          func,
	input  logic [evsa_pkg::VERTEX_W-1:0]       edge_node,
	input  logic [evsa_pkg::VERTEX_W-1:0]       segment_vertex,
	input  logic [evsa_pkg::LANE_W-1:0]         lane,
	input  logic signed [evsa_pkg::VALUE_W-1:0] value,

	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [evsa_pkg::VERTEX_W-1:0]       vertex,
	output logic [evsa_pkg::LANE_W-1:0]         out_lane,
	output logic signed [evsa_pkg::SUM_W-1:0]   sum
);

	evsa_pkg::cfg_t cfg_q;
	logic [1:0]     reg_idx;
	logic           busy;
	logic           q_ready;
	logic           push;
	evsa_pkg::op_t  push_op;
	logic           pop;
	logic           head_valid;
	evsa_pkg::op_t  head_op;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// Register writes complete in the access cycle of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= 1'b0;
			cfg_q.vertex_count  <= evsa_pkg::VERTEX_COUNT_RST;
			cfg_q.feature_count <= evsa_pkg::FEATURE_COUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				evsa_pkg::REG_MODE:          cfg_q.mode          <= pwdata[0];
				evsa_pkg::REG_VERTEX_COUNT:  cfg_q.vertex_count  <= pwdata[8:0];
				evsa_pkg::REG_FEATURE_COUNT: cfg_q.feature_count <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			evsa_pkg::REG_MODE:          prdata = {31'd0, cfg_q.mode};
			evsa_pkg::REG_VERTEX_COUNT:  prdata = {23'd0, cfg_q.vertex_count};
			evsa_pkg::REG_FEATURE_COUNT: prdata = {25'd0, cfg_q.feature_count};
			default:                     prdata = '0;
		endcase
	end

	evsa_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_LANES    (MAX_LANES)
	) u_front (
		.cfg            (cfg_q),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.func           (func),
		.edge_node      (edge_node),
		.segment_vertex (segment_vertex),
		.lane           (lane),
		.value          (value),
		.busy           (busy),
		.q_ready        (q_ready),
		.push           (push),
		.op             (push_op)
	);

	evsa_queue #(
		.DEPTH (4)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.push_ready (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	evsa_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_LANES    (MAX_LANES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_op      (head_op),
		.pop          (pop),
		.busy         (busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.vertex       (vertex),
		.out_lane     (out_lane),
		.sum          (sum)
	);

endmodule

>>> hdl/evsa_ram.sv
module evsa_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; a read at the address being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/evsa_front.sv
module evsa_front #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_LANES    = 64
) (
	input  evsa_pkg::cfg_t                      cfg,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          func,
	input  logic [evsa_pkg::VERTEX_W-1:0]       edge_node,
	input  logic [evsa_pkg::VERTEX_W-1:0]       segment_vertex,
	input  logic [evsa_pkg::LANE_W-1:0]         lane,
	input  logic signed [evsa_pkg::VALUE_W-1:0] value,
	input  logic                                busy,
	input  logic                                q_ready,
	output logic                                push,
	output evsa_pkg::op_t                       op
);

	logic                              func_ok;
	logic                              vtx_ok;
	logic                              lane_ok;
	logic [evsa_pkg::VERTEX_W-1:0]     target;
	evsa_pkg::kind_t                   kind;

	// Decode the function code and pick the target vertex.
	always_comb begin
		func_ok = 1'b1;
		kind    = evsa_pkg::OP_ACC;
		target  = segment_vertex;
		case (func)
			evsa_pkg::FUNC_ACC: begin
				kind   = evsa_pkg::OP_ACC;
				target = cfg.mode ? segment_vertex : edge_node;
			end
			evsa_pkg::FUNC_RD: begin
				kind = evsa_pkg::OP_RD;
			end
			evsa_pkg::FUNC_RDCLR: begin
				kind = evsa_pkg::OP_RDCLR;
			end
			default: begin
				func_ok = 1'b0;
			end
		endcase
	end

	// Range checks against both the register and the built-in store size.
	assign vtx_ok  = ({1'b0, target} < cfg.vertex_count) && (32'(target) < MAX_VERTICES);
	assign lane_ok = ({1'b0, lane} < cfg.feature_count) && (32'(lane) < MAX_LANES);

	// Items are taken whenever the queue has room and the store is ready;
	// only operations that touch the store are queued.
	assign item_ready = q_ready && !busy;
	assign push       = item_valid && item_ready && func_ok && vtx_ok && lane_ok;

	assign op.kind   = kind;
	assign op.vertex = target;
	assign op.lane   = lane;
	assign op.value  = value;

endmodule

>>> hdl/evsa_queue.sv
module evsa_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  evsa_pkg::op_t push_op,
	output logic          push_ready,
	input  logic          pop,
	output logic          head_valid,
	output evsa_pkg::op_t head_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	evsa_pkg::op_t   entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign push_ready = (32'(count_q) < DEPTH);
	assign head_valid = (count_q != '0);
	assign head_op    = entries_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

>>> hdl/evsa_back.sv
`include "edge_to_vertex_scatter_add_assert.svh"

module evsa_back #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_LANES    = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  evsa_pkg::op_t                       head_op,
	output logic                                pop,
	output logic                                busy,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [evsa_pkg::VERTEX_W-1:0]       vertex,
	output logic [evsa_pkg::LANE_W-1:0]         out_lane,
	output logic signed [evsa_pkg::SUM_W-1:0]   sum
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int LW    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int AW    = VW + LW;
	localparam int DEPTH = 2 ** AW;
	localparam int VXW   = (VW > evsa_pkg::VERTEX_W) ? VW : evsa_pkg::VERTEX_W;
	localparam int LXW   = (LW > evsa_pkg::LANE_W) ? LW : evsa_pkg::LANE_W;

	// Clearing pass state.
	logic                              clear_q;
	logic [AW-1:0]                     clr_addr_q;

	// Read-modify-write stage.
	logic                              v_s2;
	evsa_pkg::op_t                     op_s2;
	logic [AW-1:0]                     addr_s2;

	// Last write seen by the stage, for forwarding.
	logic                              fw_v_q;
	logic [AW-1:0]                     fw_addr_q;
	logic signed [evsa_pkg::SUM_W-1:0] fw_data_q;

	logic [VXW-1:0]                    head_vx;
	logic [LXW-1:0]                    head_lx;
	logic [AW-1:0]                     head_addr;
	logic [evsa_pkg::SUM_W-1:0]        rdata;
	logic signed [evsa_pkg::SUM_W-1:0] old_val;
	logic signed [evsa_pkg::SUM_W:0]   sum_ext;
	logic signed [evsa_pkg::SUM_W-1:0] sat_val;
	logic                              adv_s2;
	logic                              item_we;
	logic signed [evsa_pkg::SUM_W-1:0] item_wdata;
	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [evsa_pkg::SUM_W-1:0]        ram_wdata;

	// Store address of the queue head: vertex row, lane column.
	assign head_vx   = VXW'(head_op.vertex);
	assign head_lx   = LXW'(head_op.lane);
	assign head_addr = {head_vx[VW-1:0], head_lx[LW-1:0]};

	// The stage moves on unless it holds a read whose result has no room.
	assign adv_s2 = !v_s2 || (op_s2.kind == evsa_pkg::OP_ACC) || !result_valid || result_ready;
	assign pop    = !clear_q && head_valid && adv_s2;
	assign busy   = clear_q;

	// Current accumulator value, taking the write of the same edge into account.
	assign old_val = (fw_v_q && (fw_addr_q == addr_s2)) ? fw_data_q : $signed(rdata);

	// Saturating add of the Q16.16 element into the Q24.16 sum.
	always_comb begin
		sum_ext = (evsa_pkg::SUM_W + 1)'(old_val) + (evsa_pkg::SUM_W + 1)'(op_s2.value);
		if (sum_ext[evsa_pkg::SUM_W] != sum_ext[evsa_pkg::SUM_W-1]) begin
			sat_val = sum_ext[evsa_pkg::SUM_W] ? evsa_pkg::SUM_MIN : evsa_pkg::SUM_MAX;
		end else begin
			sat_val = sum_ext[evsa_pkg::SUM_W-1:0];
		end
	end

	// Write back for accumulate and read-then-clear; plain reads leave the store.
	assign item_we    = v_s2 && adv_s2 && (op_s2.kind != evsa_pkg::OP_RD);
	assign item_wdata = (op_s2.kind == evsa_pkg::OP_ACC) ? sat_val : '0;

	// The clearing pass owns the write port until it finishes.
	assign ram_we    = clear_q || item_we;
	assign ram_waddr = clear_q ? clr_addr_q : addr_s2;
	assign ram_wdata = clear_q ? '0 : item_wdata;

	evsa_ram #(
		.WIDTH (evsa_pkg::SUM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop),
		.raddr (head_addr),
		.rdata (rdata)
	);

	// Clearing pass after reset, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clear_q <= 1'b0;
			end
		end
	end

	// Stage and forwarding control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			fw_v_q <= 1'b0;
		end else begin
			if (adv_s2) begin
				v_s2 <= pop;
			end
			if (pop) begin
				fw_v_q <= item_we;
			end
		end
	end

	// Stage and forwarding payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s2     <= head_op;
			addr_s2   <= head_addr;
			fw_addr_q <= addr_s2;
			fw_data_q <= item_wdata;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (v_s2 && adv_s2 && (op_s2.kind != evsa_pkg::OP_ACC)) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && adv_s2 && (op_s2.kind != evsa_pkg::OP_ACC)) begin
			vertex   <= op_s2.vertex;
			out_lane <= op_s2.lane;
			sum      <= old_val;
		end
	end

	`EVSA_NEVER(a_no_pop_in_clear, clear_q && pop, "operation issued during clearing pass")
	`EVSA_ASSERT(a_read_no_write, (ram_we && !clear_q) |-> (op_s2.kind != evsa_pkg::OP_RD), "plain read wrote the store")
	`EVSA_ASSERT(a_clear_full_sweep, $fell(clear_q) |-> ($past(clr_addr_q) == '1), "clearing pass ended early")
	`EVSA_ASSERT(a_rdclr_fwd_zero, (pop && item_we && (op_s2.kind == evsa_pkg::OP_RDCLR)) |=> (fw_v_q && (fw_data_q == '0)), "cleared entry not forwarded as zero")

endmodule
